// ----- rtl/core/fwir_pkg.sv -----
package fwir_pkg;

  // Queue geometry
  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  // Occupancy is kept at least as wide as the 5-bit count field
  localparam int OCC_W = (CNT_W > 5) ? CNT_W : 5;

  // Field widths
  localparam int DATA_W  = 32;
  localparam int MODE_W  = 2;
  localparam int POS_W   = 4;
  localparam int COUNT_W = 5;
  localparam int STAT_W  = 2;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_ENQ = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEQ = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REM = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // capture the incoming beat
    logic exec;   // apply the captured operation
  } fwir_cmd_t;

endpackage

// ----- rtl/core/fwir_datapath.sv -----
module fwir_datapath
  import fwir_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  fwir_cmd_t                cmd,
  input  logic [MODE_W-1:0]        mode,
  input  logic signed [DATA_W-1:0] value,
  input  logic [POS_W-1:0]         position,
  output logic signed [DATA_W-1:0] front_value,
  output logic [COUNT_W-1:0]       entry_count,
  output logic                     is_empty,
  output logic [STAT_W-1:0]        status
);

  logic [MODE_W-1:0]        in_mode;
  logic signed [DATA_W-1:0] in_value;
  logic [POS_W-1:0]         in_position;

  logic [DATA_W-1:0] entries      [DEPTH];
  logic [DATA_W-1:0] entries_next [DEPTH];
  logic [OCC_W-1:0]  occ;
  logic [OCC_W-1:0]  occ_next;
  logic [STAT_W-1:0] status_next;

  logic             do_enq;
  logic             do_rm;
  logic [OCC_W-1:0] rm_pos;

  // Capture the operation
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_mode     <= mode;
      in_value    <= value;
      in_position <= position;
    end
  end

  // Decide the operation and its status
  always_comb begin
    do_enq      = 1'b0;
    do_rm       = 1'b0;
    rm_pos      = '0;
    status_next = ST_OK;
    occ_next    = occ;
    unique case (in_mode)
      MODE_ENQ: begin
        if (occ == OCC_W'(DEPTH)) begin
          status_next = ST_FULL;
        end else begin
          do_enq   = 1'b1;
          occ_next = occ + 1'b1;
        end
      end
      MODE_DEQ, MODE_REM: begin
        if (in_mode == MODE_REM) begin
          rm_pos = OCC_W'(in_position);
        end
        if (occ == '0) begin
          status_next = ST_EMPTY;
        end else if (rm_pos >= occ) begin
          status_next = ST_RANGE;
        end else begin
          do_rm    = 1'b1;
          occ_next = occ - 1'b1;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // Each cell loads the tail value or takes its neighbor to close a gap
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    if (k < DEPTH - 1) begin : g_mid
      always_comb begin
        if (do_enq && occ == OCC_W'(k)) begin
          entries_next[k] = in_value;
        end else if (do_rm && OCC_W'(k) >= rm_pos) begin
          entries_next[k] = entries[k+1];
        end else begin
          entries_next[k] = entries[k];
        end
      end
    end else begin : g_last
      always_comb begin
        if (do_enq && occ == OCC_W'(k)) begin
          entries_next[k] = in_value;
        end else begin
          entries_next[k] = entries[k];
        end
      end
    end
  end

  // Store cells
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      entries <= entries_next;
      status  <= status_next;
    end
  end

  // Hold occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (cmd.exec) begin
      occ <= occ_next;
    end
  end

  // Result fields straight from the stored state
  assign is_empty    = (occ == '0);
  assign front_value = is_empty ? '0 : entries[0];
  assign entry_count = occ[COUNT_W-1:0];

endmodule

// ----- rtl/core/fwir_ctrl.sv -----
module fwir_ctrl
  import fwir_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  output fwir_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SEND
  } state_t;

  state_t state;

  // Sequence: take a beat, apply it, offer the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      s_tready <= 1'b1;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state    <= S_EXEC;
            s_tready <= 1'b0;
          end
        end
        S_EXEC: begin
          state    <= S_SEND;
          m_tvalid <= 1'b1;
        end
        S_SEND: begin
          if (m_tready) begin
            state    <= S_IDLE;
            m_tvalid <= 1'b0;
            s_tready <= 1'b1;
          end
        end
        default: begin
          state    <= S_IDLE;
          s_tready <= 1'b1;
          m_tvalid <= 1'b0;
        end
      endcase
    end
  end

  assign cmd.load = s_tvalid && s_tready;
  assign cmd.exec = (state == S_EXEC);

endmodule

// ----- rtl/core/fifo_with_indexed_removal.sv -----
// Bounded queue of DEPTH signed 32-bit entries. Each input beat carries one
// operation in tuser: enqueue the value, dequeue the front, or remove the
// entry at a position counted from the front, later entries moving up one
// place. Every beat gives one result beat with the front value (zero when
// empty), the entry count, an empty flag and a status (ok, empty, full,
// position out of range); a rejected operation changes nothing. Items are
// handled one at a time: the beat is captured, applied to the entry cells,
// then offered on the output, and no new beat is taken until the result
// is accepted. All cells compact together when the operation is applied;
// the controller's take/apply/send sequence sets the rate.
module fifo_with_indexed_removal
  import fwir_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // value[31:0], position[35:32], zero fill
  input  logic [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // front_value[31:0], entry_count[36:32],
                                 // is_empty[37], status[39:38]
);

  fwir_cmd_t                cmd;
  logic signed [DATA_W-1:0] front_value;
  logic [COUNT_W-1:0]       entry_count;
  logic                     is_empty;
  logic [STAT_W-1:0]        status;

  fwir_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  fwir_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .mode        (s_tuser[MODE_W-1:0]),
    .value       (s_tdata[DATA_W-1:0]),
    .position    (s_tdata[DATA_W+POS_W-1:DATA_W]),
    .front_value (front_value),
    .entry_count (entry_count),
    .is_empty    (is_empty),
    .status      (status)
  );

  // Pack the result beat
  assign m_tdata = {status, is_empty, entry_count, front_value};

endmodule

// ----- rtl/core/fwir_checker.sv -----
module fwir_checker
  import fwir_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // One item in flight: no second beat right after one is taken
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an item is in flight");

  // Empty flag agrees with the count
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[37] == (m_tdata[36:32] == 5'd0)))
    else $error("empty flag disagrees with entry count");

  // Empty queue shows a zero front
  a_empty_front: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[37]) |-> (m_tdata[31:0] == 32'd0))
    else $error("front value not zero on empty queue");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result beat changed");

endmodule

bind fifo_with_indexed_removal fwir_checker u_fwir_checker (.*);
